// ----- src/gsa_pkg.sv -----
// Shared types and constants for the generational slot allocator.
`default_nettype none
package gsa_pkg;

  // default geometry
  localparam int SLOTS_DEF    = 1024;
  localparam int GEN_BITS_DEF = 16;

  // active bits are stored this many to a memory word
  localparam int WORD_BITS = 32;
  localparam int BIT_W     = 5;

  // fixed transaction field widths
  localparam int IDX_IN_W = 10;
  localparam int GEN_IO_W = 16;

  typedef enum logic [1:0] {
    MODE_ALLOC   = 2'd0,
    MODE_FORCE   = 2'd1,
    MODE_RELEASE = 2'd2,
    MODE_CHECK   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STS_OK    = 2'd0,
    STS_FULL  = 2'd1,
    STS_RANGE = 2'd2,
    STS_STALE = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FIND,
    ST_UPDATE
  } state_t;

endpackage
`default_nettype wire

// ----- src/gsa_first_zero.sv -----
// Priority encoder that finds the lowest clear bit of a vector.
`default_nettype none
module gsa_first_zero
  import gsa_pkg::*;
#(
  parameter int W  = WORD_BITS,
  parameter int IW = (W > 1) ? $clog2(W) : 1
) (
  input  wire logic [W-1:0]  bits,
  output logic               found,
  output logic [IW-1:0]      pos
);

  // scan from the top so the lowest clear bit wins
  always_comb begin
    found = 1'b0;
    pos   = '0;
    for (int i = W - 1; i >= 0; i--) begin
      if (!bits[i]) begin
        found = 1'b1;
        pos   = IW'(i);
      end
    end
  end

endmodule
`default_nettype wire

// ----- src/generational_slot_allocator.sv -----
// Top level: generational slot table with active-bit and generation memories.
//
//   channel  direction  handshake             payload
//   in_      input      in_valid / in_ready   mode, slot_index, handle_generation
//   out_     output     out_valid / out_ready result_index, result_generation, status
//
// Each transaction passes through accept (active-word read), find (first
// free bit, generation read) and update (write back, load the output register).
// The registered reads of the two memories set these steps.
// After reset a clearing pass zeroes the generation memory and the active-bit
// words (padding bits of the last word set); in_ready stays low meanwhile.
// A full output register stalls the update cycle until out_ready frees it.
`default_nettype none
module generational_slot_allocator
  import gsa_pkg::*;
#(
  parameter int SLOTS    = SLOTS_DEF,
  parameter int GEN_BITS = GEN_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [1:0]          in_mode,
  input  wire logic [IDX_IN_W-1:0] in_slot_index,
  input  wire logic [GEN_IO_W-1:0] in_handle_generation,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [IDX_IN_W-1:0]      out_result_index,
  output logic [GEN_IO_W-1:0]      out_result_generation,
  output logic [1:0]               out_status
);

  localparam int IDX_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W     = $clog2(SLOTS + 1);
  localparam int CMP_W     = (CNT_W > IDX_IN_W) ? CNT_W : IDX_IN_W;
  localparam int NUM_WORDS = (SLOTS + WORD_BITS - 1) / WORD_BITS;
  localparam int WA_W      = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int SLOT_W    = WA_W + BIT_W;
  localparam int GX_W      = (GEN_BITS > GEN_IO_W) ? GEN_BITS : GEN_IO_W;
  localparam int LAST_BITS = SLOTS - (NUM_WORDS - 1) * WORD_BITS;
  localparam logic [WORD_BITS-1:0] LAST_PAD =
    WORD_BITS'(~((64'd1 << LAST_BITS) - 64'd1));

  // control state
  state_t                 state_r, state_nxt;
  logic [CNT_W-1:0]       clr_r, clr_nxt;
  logic [CNT_W-1:0]       count_r, count_nxt;
  logic [NUM_WORDS-1:0]   word_full_r, word_full_nxt;
  logic                   out_valid_r, out_valid_nxt;

  // latched request
  mode_t                  mode_r;
  logic [CMP_W-1:0]       idx_r;
  logic [GEN_IO_W-1:0]    hgen_r;
  logic                   none_free_r;
  logic [WA_W-1:0]        word_r;
  logic [BIT_W-1:0]       bit_r, bit_nxt;

  // memories and registered read data
  logic [WORD_BITS-1:0]   act_mem [NUM_WORDS];
  logic [GEN_BITS-1:0]    gen_mem [SLOTS];
  logic [WORD_BITS-1:0]   act_rd_r;
  logic [GEN_BITS-1:0]    gen_rd_r;

  logic                   act_re, act_we, gen_re, gen_we;
  logic [WA_W-1:0]        act_raddr, act_waddr;
  logic [WORD_BITS-1:0]   act_wdata;
  logic [IDX_W-1:0]       gen_raddr, gen_waddr;
  logic [GEN_BITS-1:0]    gen_wdata;

  // output register
  logic [IDX_IN_W-1:0]    out_idx_r, out_idx_nxt;
  logic [GEN_IO_W-1:0]    out_gen_r, out_gen_nxt;
  status_t                out_sts_r, out_sts_nxt;
  logic                   load_out;

  // request decode helpers
  logic                   accept;
  logic [CMP_W-1:0]       in_idx_x;
  logic                   word_found;
  logic [WA_W-1:0]        free_word;
  logic                   bit_found;
  logic [BIT_W-1:0]       free_bit;
  logic [SLOT_W-1:0]      find_slot, upd_slot;
  logic [CMP_W-1:0]       upd_slot_x, slot_limit;
  logic                   in_slots, below_count;
  logic [GX_W-1:0]        hgen_x, stored_x, newgen_x;
  logic [GEN_BITS-1:0]    gen_inc;
  logic [WORD_BITS-1:0]   bit_mask;
  logic                   proceed;

  assign accept   = in_valid && in_ready;
  assign in_idx_x = CMP_W'(in_slot_index);

  // first word with a free slot
  gsa_first_zero #(.W(NUM_WORDS), .IW(WA_W)) u_word_enc (
    .bits  (word_full_r),
    .found (word_found),
    .pos   (free_word)
  );

  // first free bit of the word just read
  gsa_first_zero #(.W(WORD_BITS), .IW(BIT_W)) u_bit_enc (
    .bits  (act_rd_r),
    .found (bit_found),
    .pos   (free_bit)
  );

  // slot arithmetic for the find and update cycles
  always_comb begin
    bit_nxt    = (mode_r == MODE_ALLOC && bit_found) ? free_bit : idx_r[BIT_W-1:0];
    find_slot  = {word_r, bit_nxt};
    upd_slot   = {word_r, bit_r};
    upd_slot_x = CMP_W'(upd_slot);
    slot_limit = CMP_W'(SLOTS);
    in_slots   = idx_r < slot_limit;
    below_count = idx_r < CMP_W'(count_r);
    hgen_x     = GX_W'(hgen_r);
    stored_x   = GX_W'(gen_rd_r);
    gen_inc    = gen_rd_r + GEN_BITS'(1);
    bit_mask   = WORD_BITS'(1) << bit_r;
    proceed    = !out_valid_r || out_ready;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR:  if (clr_r == CNT_W'(SLOTS - 1)) state_nxt = ST_IDLE;
      ST_IDLE:   if (accept) state_nxt = ST_FIND;
      ST_FIND:   state_nxt = ST_UPDATE;
      ST_UPDATE: if (proceed) state_nxt = ST_IDLE;
      default:   state_nxt = ST_CLEAR;
    endcase
  end

  // datapath and memory control
  always_comb begin
    in_ready      = 1'b0;
    clr_nxt       = clr_r;
    count_nxt     = count_r;
    word_full_nxt = word_full_r;
    act_re        = 1'b0;
    act_raddr     = '0;
    act_we        = 1'b0;
    act_waddr     = word_r;
    act_wdata     = act_rd_r;
    gen_re        = 1'b0;
    gen_raddr     = find_slot[IDX_W-1:0];
    gen_we        = 1'b0;
    gen_waddr     = upd_slot[IDX_W-1:0];
    gen_wdata     = gen_rd_r;
    load_out      = 1'b0;
    newgen_x      = '0;
    out_idx_nxt   = idx_r[IDX_IN_W-1:0];
    out_gen_nxt   = '0;
    out_sts_nxt   = STS_OK;
    unique case (state_r)
      ST_CLEAR: begin
        // sweep both memories back to their reset contents
        clr_nxt   = clr_r + CNT_W'(1);
        gen_we    = 1'b1;
        gen_waddr = clr_r[IDX_W-1:0];
        gen_wdata = '0;
        if (clr_r < CNT_W'(NUM_WORDS)) begin
          act_we    = 1'b1;
          act_waddr = clr_r[WA_W-1:0];
          act_wdata = (clr_r == CNT_W'(NUM_WORDS - 1)) ? LAST_PAD : '0;
        end
      end
      ST_IDLE: begin
        // read the active word that holds the target slot
        in_ready  = 1'b1;
        act_re    = accept;
        act_raddr = (mode_t'(in_mode) == MODE_ALLOC) ? free_word
                                                     : in_idx_x[WA_W+BIT_W-1:BIT_W];
      end
      ST_FIND: begin
        gen_re = 1'b1;
      end
      ST_UPDATE: begin
        // modify and write back where the mode changes the table, then load the result
        load_out = proceed;
        unique case (mode_r)
          MODE_ALLOC: begin
            if (none_free_r) begin
              out_idx_nxt = '0;
              out_sts_nxt = STS_FULL;
            end else begin
              act_we      = proceed;
              act_wdata   = act_rd_r | bit_mask;
              gen_we      = proceed;
              gen_wdata   = gen_inc;
              newgen_x    = GX_W'(gen_inc);
              out_idx_nxt = upd_slot_x[IDX_IN_W-1:0];
              out_gen_nxt = newgen_x[GEN_IO_W-1:0];
              if (proceed && upd_slot_x >= CMP_W'(count_r))
                count_nxt = CNT_W'(upd_slot_x + CMP_W'(1));
              if (proceed)
                word_full_nxt[word_r] = &(act_rd_r | bit_mask);
            end
          end
          MODE_FORCE: begin
            if (!in_slots) begin
              out_sts_nxt = STS_RANGE;
            end else begin
              act_we      = proceed;
              act_wdata   = act_rd_r | bit_mask;
              gen_we      = proceed;
              gen_wdata   = hgen_x[GEN_BITS-1:0];
              newgen_x    = GX_W'(hgen_x[GEN_BITS-1:0]);
              out_gen_nxt = newgen_x[GEN_IO_W-1:0];
              if (proceed && idx_r >= CMP_W'(count_r))
                count_nxt = CNT_W'(idx_r + CMP_W'(1));
              if (proceed)
                word_full_nxt[word_r] = &(act_rd_r | bit_mask);
            end
          end
          MODE_RELEASE: begin
            if (!below_count) begin
              out_sts_nxt = STS_RANGE;
            end else begin
              act_we      = proceed;
              act_wdata   = act_rd_r & ~bit_mask;
              out_gen_nxt = stored_x[GEN_IO_W-1:0];
              if (proceed)
                word_full_nxt[word_r] = 1'b0;
            end
          end
          MODE_CHECK: begin
            if (!below_count) begin
              out_sts_nxt = STS_RANGE;
            end else begin
              out_gen_nxt = stored_x[GEN_IO_W-1:0];
              out_sts_nxt = ((act_rd_r & bit_mask) != '0 && stored_x == hgen_x)
                            ? STS_OK : STS_STALE;
            end
          end
          default: out_sts_nxt = STS_OK;
        endcase
      end
      default: clr_nxt = '0;
    endcase
  end

  // output valid: set on load, drop when the transaction leaves
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      count_r     <= '0;
      word_full_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      count_r     <= count_nxt;
      word_full_r <= word_full_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // request and result registers
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r      <= mode_t'(in_mode);
      idx_r       <= in_idx_x;
      hgen_r      <= in_handle_generation;
      none_free_r <= !word_found;
      word_r      <= act_raddr;
    end
    if (state_r == ST_FIND) bit_r <= bit_nxt;
    if (load_out) begin
      out_idx_r <= out_idx_nxt;
      out_gen_r <= out_gen_nxt;
      out_sts_r <= out_sts_nxt;
    end
  end

  // active-bit memory
  always_ff @(posedge clk) begin
    if (act_we) act_mem[act_waddr] <= act_wdata;
    if (act_re) act_rd_r <= act_mem[act_raddr];
  end

  // generation memory
  always_ff @(posedge clk) begin
    if (gen_we) gen_mem[gen_waddr] <= gen_wdata;
    if (gen_re) gen_rd_r <= gen_mem[gen_raddr];
  end

  assign out_valid             = out_valid_r;
  assign out_result_index      = out_idx_r;
  assign out_result_generation = out_gen_r;
  assign out_status            = out_sts_r;

endmodule
`default_nettype wire

// ----- tb/gsa_slot_checker.sv -----
// Predictor and scoreboard that watch both channels of the slot allocator.
module gsa_slot_checker
  import gsa_pkg::*;
#(
  parameter int SLOTS    = SLOTS_DEF,
  parameter int GEN_BITS = GEN_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  input  wire logic                in_ready,
  input  wire logic [1:0]          in_mode,
  input  wire logic [IDX_IN_W-1:0] in_slot_index,
  input  wire logic [GEN_IO_W-1:0] in_handle_generation,
  input  wire logic                out_valid,
  input  wire logic                out_ready,
  input  wire logic [IDX_IN_W-1:0] out_result_index,
  input  wire logic [GEN_IO_W-1:0] out_result_generation,
  input  wire logic [1:0]          out_status,
  output int                       fail_count,
  output int                       pending
);

  typedef struct packed {
    logic [IDX_IN_W-1:0] index;
    logic [GEN_IO_W-1:0] generation;
    status_t             status;
  } slot_result_t;

  // shadow of the slot table
  bit                  slot_live [SLOTS];
  logic [GEN_BITS-1:0] slot_gen  [SLOTS];
  int                  high_water;

  slot_result_t expected_q [$];

  task automatic report_mismatch(input string what);
    $display("[%0t] MISMATCH: %s", $time, what);
    fail_count = fail_count + 1;
  endtask

  // Apply one request to the shadow table and return the handle it yields.
  function automatic slot_result_t apply_request(input logic [1:0]          mode,
                                                 input logic [IDX_IN_W-1:0] idx,
                                                 input logic [GEN_IO_W-1:0] hgen);
    slot_result_t res;
    int           hole;
    int           i;
    res.index      = idx;
    res.generation = '0;
    res.status     = STS_OK;
    case (mode)
      MODE_ALLOC: begin
        // reuse the lowest free slot below the high-water mark
        hole = -1;
        for (i = 0; i < high_water && i < SLOTS && hole < 0; i++) begin
          if (!slot_live[i]) hole = i;
        end
        if (hole >= 0) begin
          slot_gen[hole]  = slot_gen[hole] + 1'b1;
          slot_live[hole] = 1'b1;
          res.index       = IDX_IN_W'(hole);
          res.generation  = GEN_IO_W'(slot_gen[hole]);
        end else if (high_water < SLOTS) begin
          slot_live[high_water] = 1'b1;
          slot_gen[high_water]  = GEN_BITS'(1);
          res.index             = IDX_IN_W'(high_water);
          res.generation        = GEN_IO_W'(1);
          high_water            = high_water + 1;
        end else begin
          res.index  = '0;
          res.status = STS_FULL;
        end
      end
      MODE_FORCE: begin
        if (int'(idx) >= SLOTS) begin
          res.status = STS_RANGE;
        end else begin
          slot_live[idx] = 1'b1;
          slot_gen[idx]  = GEN_BITS'(hgen);
          if (int'(idx) + 1 > high_water) high_water = int'(idx) + 1;
          res.generation = GEN_IO_W'(slot_gen[idx]);
        end
      end
      default: begin
        // release and check share the range test
        if (int'(idx) >= high_water || int'(idx) >= SLOTS) begin
          res.status = STS_RANGE;
        end else begin
          res.generation = GEN_IO_W'(slot_gen[idx]);
          if (mode == MODE_RELEASE) begin
            slot_live[idx] = 1'b0;
          end else if (!(slot_live[idx] && 32'(slot_gen[idx]) == 32'(hgen))) begin
            res.status = STS_STALE;
          end
        end
      end
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    slot_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_live[i] = 1'b0;
        slot_gen[i]  = '0;
      end
      high_water = 0;
      expected_q.delete();
    end else begin
      // compare the result transaction with the oldest prediction
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result: index %0d gen %0d status %0d",
                                    out_result_index, out_result_generation, out_status));
        end else begin
          want = expected_q.pop_front();
          if (out_result_index !== want.index)
            report_mismatch($sformatf("result_index: got %0d, want %0d",
                                      out_result_index, want.index));
          if (out_result_generation !== want.generation)
            report_mismatch($sformatf("result_generation: got %0d, want %0d",
                                      out_result_generation, want.generation));
          if (out_status !== want.status)
            report_mismatch($sformatf("status: got %0d, want %0d",
                                      out_status, want.status));
        end
      end
      // predict the request transaction
      if (in_valid && in_ready)
        expected_q.push_back(apply_request(in_mode, in_slot_index, in_handle_generation));
    end
    pending <= expected_q.size();
  end

endmodule

// ----- tb/generational_slot_allocator_tb.sv -----
// Testbench top: clock, reset, request stimulus, result pacing and verdict.
module generational_slot_allocator_tb;
  import gsa_pkg::*;

  localparam int STALL_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 8;
  localparam int RANDOM_ITEMS = 400;
  localparam int FILL_ALLOCS  = 40;
  localparam int HOLD_AFTER   = 150;
  localparam int HOLD_CYCLES  = 400;

  logic                clk                  = 1'b0;
  logic                rst_n                = 1'b0;
  logic                in_valid             = 1'b0;
  logic                in_ready;
  logic [1:0]          in_mode              = MODE_ALLOC;
  logic [IDX_IN_W-1:0] in_slot_index        = '0;
  logic [GEN_IO_W-1:0] in_handle_generation = '0;
  logic                out_valid;
  logic                out_ready            = 1'b0;
  logic [IDX_IN_W-1:0] out_result_index;
  logic [GEN_IO_W-1:0] out_result_generation;
  logic [1:0]          out_status;

  int fail_count;
  int pending;

  // stimulus side bookkeeping, fed from observed results
  logic [GEN_IO_W-1:0] seen_gen [1024];
  int                  slots_used   = 0;
  int                  results_seen = 0;
  int                  burst_left   = 1;
  int                  quiet_cycles = 0;

  generational_slot_allocator dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_mode              (in_mode),
    .in_slot_index        (in_slot_index),
    .in_handle_generation (in_handle_generation),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_result_index     (out_result_index),
    .out_result_generation(out_result_generation),
    .out_status           (out_status)
  );

  gsa_slot_checker slot_check (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_mode              (in_mode),
    .in_slot_index        (in_slot_index),
    .in_handle_generation (in_handle_generation),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_result_index     (out_result_index),
    .out_result_generation(out_result_generation),
    .out_status           (out_status),
    .fail_count           (fail_count),
    .pending              (pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Offer one request and hold it until accepted; idle between bursts.
  task automatic offer(input logic [1:0] m, input logic [IDX_IN_W-1:0] idx,
                       input logic [GEN_IO_W-1:0] g);
    in_valid             <= 1'b1;
    in_mode              <= m;
    in_slot_index        <= idx;
    in_handle_generation <= g;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left = burst_left - 1;
    if (burst_left <= 0) begin
      burst_left = ($urandom_range(7) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
      if ($urandom_range(3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  endtask

  // Pick a random request, mostly aimed at live slots and known handles.
  task automatic choose_request(output logic [1:0] m, output logic [IDX_IN_W-1:0] idx,
                                output logic [GEN_IO_W-1:0] g);
    int roll;
    int lim;
    roll = $urandom_range(99);
    lim  = (slots_used + 2 > 1023) ? 1023 : slots_used + 2;
    idx  = IDX_IN_W'($urandom_range(lim));
    g    = GEN_IO_W'($urandom);
    if (roll < 35) begin
      m = MODE_ALLOC;
    end else if (roll < 45) begin
      m = MODE_FORCE;
      case ($urandom_range(4))
        0:       g = 16'hFFFF;
        1:       g = '0;
        2:       g = 16'hFFFE;
        3:       g = GEN_IO_W'($urandom_range(1, 20));
        default: ;
      endcase
    end else begin
      m = (roll < 70) ? MODE_RELEASE : MODE_CHECK;
      // now and then aim past the high-water mark
      if ($urandom_range(9) == 0) idx = IDX_IN_W'($urandom);
      if (m == MODE_CHECK) begin
        case ($urandom_range(9))
          0, 1:    ;
          2:       g = seen_gen[idx] + 1'b1;
          default: g = seen_gen[idx];
        endcase
      end
    end
  endtask

  // Track handles seen on the result channel for later checks.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      results_seen <= results_seen + 1;
      if (out_status == STS_OK || out_status == STS_STALE) begin
        seen_gen[out_result_index] <= out_result_generation;
        if (int'(out_result_index) >= slots_used) slots_used <= int'(out_result_index) + 1;
      end
    end
  end

  // Stall the result channel on changing patterns, with one long hold-off.
  initial begin : result_pacing
    int style;
    int phase_len;
    int tick;
    bit held;
    held = 1'b0;
    tick = 0;
    forever begin
      style     = $urandom_range(3);
      phase_len = $urandom_range(20, 120);
      repeat (phase_len) begin
        @(posedge clk);
        tick = tick + 1;
        if (!held && results_seen >= HOLD_AFTER) begin
          held = 1'b1;
          out_ready <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk);
        end
        case (style)
          0:       out_ready <= 1'b1;
          1:       out_ready <= ($urandom_range(3) == 0);
          2:       out_ready <= ($urandom_range(3) != 0);
          default: out_ready <= ((tick % 5) < 2);
        endcase
      end
    end
  end

  // End the run when no transaction moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [1:0]          m;
    logic [IDX_IN_W-1:0] idx;
    logic [GEN_IO_W-1:0] g;
    for (int i = 0; i < 1024; i++) seen_gen[i] = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty table, reuse, stale handles, wrap, forced slots, range
    offer(MODE_CHECK,   10'd0,    16'd0);
    offer(MODE_RELEASE, 10'd0,    16'd0);
    offer(MODE_ALLOC,   10'h3FF,  16'hFFFF);
    offer(MODE_ALLOC,   10'h155,  16'hAAAA);
    offer(MODE_ALLOC,   10'h2AA,  16'h5555);
    offer(MODE_CHECK,   10'd1,    16'd1);
    offer(MODE_CHECK,   10'd1,    16'd2);
    offer(MODE_RELEASE, 10'd1,    16'd0);
    offer(MODE_RELEASE, 10'd1,    16'd0);
    offer(MODE_CHECK,   10'd1,    16'd1);
    offer(MODE_ALLOC,   10'd0,    16'd0);
    offer(MODE_FORCE,   10'd0,    16'hFFFF);
    offer(MODE_RELEASE, 10'd0,    16'd0);
    offer(MODE_ALLOC,   10'd0,    16'd0);
    offer(MODE_CHECK,   10'd0,    16'd0);
    offer(MODE_FORCE,   10'd6,    16'hA5A5);
    offer(MODE_CHECK,   10'd4,    16'd0);
    offer(MODE_ALLOC,   10'd0,    16'd0);
    offer(MODE_CHECK,   10'd1023, 16'hFFFF);
    offer(MODE_RELEASE, 10'd1023, 16'd0);
    offer(MODE_FORCE,   10'd2,    16'h5A5A);
    offer(MODE_CHECK,   10'd2,    16'h5A5A);
    offer(MODE_CHECK,   10'd7,    16'd0);
    offer(MODE_FORCE,   10'd3,    16'd0);

    // random mix of operations
    repeat (RANDOM_ITEMS) begin
      choose_request(m, idx, g);
      offer(m, idx, g);
    end

    // raise the mark to the top, then fill the lowest holes
    offer(MODE_FORCE, 10'd1023, 16'h3C3C);
    repeat (FILL_ALLOCS) offer(MODE_ALLOC, IDX_IN_W'($urandom), GEN_IO_W'($urandom));

    // churn the table: free one slot, refill holes, check the freed handle
    repeat (10) begin
      idx = IDX_IN_W'($urandom);
      offer(MODE_RELEASE, idx, GEN_IO_W'($urandom));
      offer(MODE_ALLOC, IDX_IN_W'($urandom), GEN_IO_W'($urandom));
      offer(MODE_ALLOC, IDX_IN_W'($urandom), GEN_IO_W'($urandom));
      offer(MODE_CHECK, idx, seen_gen[idx]);
    end
    in_valid <= 1'b0;

    // drain outstanding results, then give the verdict
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
